// File: hw/rtl/chfsm_pkg.sv
// chfsm_pkg: shared types, codes and timer helpers of the connection handshake engine
// no dependencies; used by the register bank, the engine and the top level

package chfsm_pkg;

  // signed width of the retry, link and keep-alive timers
  localparam int TIMER_BITS = 32;
  // working width for timer arithmetic: room for a 20-bit reload plus sign and carry
  localparam int EXT_W = ((TIMER_BITS > 21) ? TIMER_BITS : 21) + 2;

  typedef logic signed [TIMER_BITS-1:0] timer_t;
  typedef logic signed [EXT_W-1:0]      wide_t;

  localparam wide_t T_HI = wide_t'({1'b0, {(TIMER_BITS-1){1'b1}}});
  localparam wide_t T_LO = ~T_HI;

  // event codes
  localparam logic [3:0] FN_TICK        = 4'd0;
  localparam logic [3:0] FN_START       = 4'd1;
  localparam logic [3:0] FN_DISCONNECT  = 4'd2;
  localparam logic [3:0] FN_RX_CONNECT  = 4'd3;
  localparam logic [3:0] FN_RX_ACCEPTED = 4'd4;
  localparam logic [3:0] FN_RX_DENIED   = 4'd5;
  localparam logic [3:0] FN_RX_CONN_ACK = 4'd6;
  localparam logic [3:0] FN_RX_PING     = 4'd7;
  localparam logic [3:0] FN_RX_PONG     = 4'd8;
  localparam logic [3:0] FN_RX_ACK      = 4'd9;
  localparam logic [3:0] FN_RX_DATA     = 4'd10;

  // outgoing message kinds
  localparam logic [2:0] K_CONNECT  = 3'd0;
  localparam logic [2:0] K_ACCEPTED = 3'd1;
  localparam logic [2:0] K_CONN_ACK = 3'd2;
  localparam logic [2:0] K_PING     = 3'd3;
  localparam logic [2:0] K_PONG     = 3'd4;

  // status and disconnect reason codes
  localparam logic [2:0] ST_NONE         = 3'd0;
  localparam logic [2:0] ST_CONNECTING   = 3'd0;
  localparam logic [2:0] ST_CONNECTED    = 3'd1;
  localparam logic [2:0] ST_DISCONNECTED = 3'd2;
  localparam logic [2:0] ST_TIMEOUT      = 3'd3;
  localparam logic [2:0] ST_USER_LIMIT   = 3'd4;
  localparam logic [2:0] ST_BY_SERVER    = 3'd5;
  localparam logic [2:0] ST_OTHER_DENIAL = 3'd6;

  // deny reasons carried by a denied message
  localparam logic [1:0] DR_USER_LIMIT = 2'd0;
  localparam logic [1:0] DR_BY_SERVER  = 2'd1;

  // link state codes as seen on the result
  localparam logic [1:0] LSC_DISC       = 2'd0;
  localparam logic [1:0] LSC_CONNECTING = 2'd1;
  localparam logic [1:0] LSC_ACCEPTED   = 2'd2;
  localparam logic [1:0] LSC_CONNECTED  = 2'd3;

  // register indexes (byte address 4*index)
  localparam int          ADDR_W = 5;
  localparam logic [2:0]  REG_RETRY_PERIOD     = 3'd0;
  localparam logic [2:0]  REG_LINK_TIMEOUT     = 3'd1;
  localparam logic [2:0]  REG_KEEPALIVE_PERIOD = 3'd2;
  localparam logic [2:0]  REG_MAX_RETRIES      = 3'd3;
  localparam logic [2:0]  REG_LOCAL_ID         = 3'd4;

  // register reset values
  localparam logic [19:0] RST_RETRY_PERIOD     = 20'd1000;
  localparam logic [19:0] RST_LINK_TIMEOUT     = 20'd10000;
  localparam logic [19:0] RST_KEEPALIVE_PERIOD = 20'd2000;
  localparam logic [7:0]  RST_MAX_RETRIES      = 8'd5;
  localparam logic [7:0]  RST_LOCAL_ID         = 8'd0;

  typedef enum logic [3:0] {
    LS_DISC       = 4'b0001,
    LS_CONNECTING = 4'b0010,
    LS_ACCEPTED   = 4'b0100,
    LS_CONNECTED  = 4'b1000
  } link_state_t;

  typedef struct packed {
    logic [19:0] retry_period;
    logic [19:0] link_timeout;
    logic [19:0] keepalive_period;
    logic [7:0]  max_retries;
  } cfg_t;

  typedef struct packed {
    logic [3:0]  func;
    logic [15:0] elapsed;
    logic [15:0] peer_session;
    logic [1:0]  deny_reason;
    logic [63:0] time_stamp;
    logic [63:0] local_now;
  } in_item_t;

  typedef struct packed {
    logic        send_valid;
    logic [2:0]  send_kind;
    logic [63:0] send_time_a;
    logic [63:0] send_time_b;
    logic [15:0] send_session;
    logic        status_valid;
    logic [2:0]  status_code;
    logic [1:0]  link_state;
    logic [2:0]  disconnect_reason;
    logic        rtt_valid;
    logic [63:0] rtt_value;
  } res_t;

  // clamp a working value into the signed timer range
  function automatic timer_t sat(wide_t v);
    wide_t c;
    if (v > T_HI) begin
      c = T_HI;
    end else if (v < T_LO) begin
      c = T_LO;
    end else begin
      c = v;
    end
    return timer_t'(c[TIMER_BITS-1:0]);
  endfunction

  // timer loaded from a 20-bit period register
  function automatic timer_t load20(logic [19:0] p);
    return sat(wide_t'({1'b0, p}));
  endfunction

  function automatic logic [1:0] ls_encode(link_state_t s);
    logic [1:0] c;
    unique case (s)
      LS_DISC:       c = LSC_DISC;
      LS_CONNECTING: c = LSC_CONNECTING;
      LS_ACCEPTED:   c = LSC_ACCEPTED;
      LS_CONNECTED:  c = LSC_CONNECTED;
      default:       c = LSC_DISC;
    endcase
    return c;
  endfunction

endpackage

// File: hw/rtl/chfsm_if.sv
// chfsm_if: valid/ready channels for event items and result items
// depends on chfsm_pkg for nothing but shares its field widths

interface chfsm_in_if;
  logic        valid;
  logic        ready;
  logic [3:0]  func;
  logic [15:0] elapsed;
  logic [15:0] peer_session;
  logic [1:0]  deny_reason;
  logic [63:0] time_stamp;
  logic [63:0] local_now;

  modport source (output valid, func, elapsed, peer_session, deny_reason, time_stamp,
                  local_now, input ready);
  modport sink (input valid, func, elapsed, peer_session, deny_reason, time_stamp,
                local_now, output ready);
endinterface

interface chfsm_out_if;
  logic        valid;
  logic        ready;
  logic        send_valid;
  logic [2:0]  send_kind;
  logic [63:0] send_time_a;
  logic [63:0] send_time_b;
  logic [15:0] send_session;
  logic        status_valid;
  logic [2:0]  status_code;
  logic [1:0]  link_state;
  logic [2:0]  disconnect_reason;
  logic        rtt_valid;
  logic [63:0] rtt_value;

  modport source (output valid, send_valid, send_kind, send_time_a, send_time_b,
                  send_session, status_valid, status_code, link_state, disconnect_reason,
                  rtt_valid, rtt_value, input ready);
  modport sink (input valid, send_valid, send_kind, send_time_a, send_time_b,
                send_session, status_valid, status_code, link_state, disconnect_reason,
                rtt_valid, rtt_value, output ready);
endinterface

// File: hw/rtl/connection_handshake_fsm_top.sv
// Connection handshake engine. Takes one event item per clock cycle while the result side
// accepts (tick, start, disconnect or a received message) and returns exactly one result
// item for each. The event enters an input register; the state machine, its retry, link
// and keep-alive timers and the session and reason registers are updated from there and
// the result is captured in an output register, so the state update loop in the engine
// sets the rate of one item per cycle. Timers are 32-bit signed and saturating; a timer
// expires when it goes below zero. Registers on the APB-style port (pready always high)
// sit at byte address 4*i: retry_period, link_timeout, keepalive_period, max_retries,
// local_id; the user must write them only while no item is in flight, which the block
// itself does not enforce. There is no clearing pass after reset.

module connection_handshake_fsm_top (
  input  logic                         clk,
  input  logic                         rst_n,
  chfsm_in_if.sink                     in_ch,
  chfsm_out_if.source                  out_ch,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [chfsm_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  chfsm_pkg::cfg_t     cfg;
  chfsm_pkg::in_item_t in_item;
  chfsm_pkg::in_item_t s1_item_r;
  logic                s1_v_r, s1_v_nxt;
  chfsm_pkg::res_t     res;
  chfsm_pkg::res_t     out_res_r;
  logic                out_v_r, out_v_nxt;
  logic                fire;
  logic                in_take;

  chfsm_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  chfsm_engine u_engine (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg),
    .fire  (fire),
    .item  (s1_item_r),
    .res   (res)
  );

  assign in_item.func         = in_ch.func;
  assign in_item.elapsed      = in_ch.elapsed;
  assign in_item.peer_session = in_ch.peer_session;
  assign in_item.deny_reason  = in_ch.deny_reason;
  assign in_item.time_stamp   = in_ch.time_stamp;
  assign in_item.local_now    = in_ch.local_now;

  // the held item moves on whenever the output register is free or being drained
  assign fire        = s1_v_r && (!out_v_r || out_ch.ready);
  assign in_ch.ready = !s1_v_r || fire;
  assign in_take     = in_ch.valid && in_ch.ready;

  always_comb begin
    s1_v_nxt = s1_v_r;
    if (in_take) begin
      s1_v_nxt = 1'b1;
    end else if (fire) begin
      s1_v_nxt = 1'b0;
    end
    out_v_nxt = out_v_r;
    if (fire) begin
      out_v_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_item_r <= in_item;
    end
    if (fire) begin
      out_res_r <= res;
    end
  end

  assign out_ch.valid             = out_v_r;
  assign out_ch.send_valid        = out_res_r.send_valid;
  assign out_ch.send_kind         = out_res_r.send_kind;
  assign out_ch.send_time_a       = out_res_r.send_time_a;
  assign out_ch.send_time_b       = out_res_r.send_time_b;
  assign out_ch.send_session      = out_res_r.send_session;
  assign out_ch.status_valid      = out_res_r.status_valid;
  assign out_ch.status_code       = out_res_r.status_code;
  assign out_ch.link_state        = out_res_r.link_state;
  assign out_ch.disconnect_reason = out_res_r.disconnect_reason;
  assign out_ch.rtt_valid         = out_res_r.rtt_valid;
  assign out_ch.rtt_value         = out_res_r.rtt_value;

`ifndef ASSERT_OFF
  // an item leaving the input register always lands in the output register
  a_fire_lands: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_v_r)
    else $error("processed item did not reach the output register");

  // a held item stays put until it is processed
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && !fire) |=> (s1_v_r && $stable(s1_item_r)))
    else $error("input register changed while its item was waiting");

  // a connected status report always comes with the connected link state
  a_connected_state: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_res_r.status_valid && out_res_r.status_code == chfsm_pkg::ST_CONNECTED)
      |-> (out_res_r.link_state == chfsm_pkg::LSC_CONNECTED))
    else $error("connected status without connected link state");
`endif

endmodule

// File: hw/rtl/chfsm_cfg.sv
// chfsm_cfg: APB-style register bank holding the timer periods, retry limit and local id
// depends on chfsm_pkg for register indexes, reset values and cfg_t

module chfsm_cfg (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [chfsm_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  output chfsm_pkg::cfg_t            cfg
);

  logic [19:0] retry_period_r;
  logic [19:0] link_timeout_r;
  logic [19:0] keepalive_period_r;
  logic [7:0]  max_retries_r;
  logic [7:0]  local_id_r;
  logic        wr_en;
  logic [2:0]  idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = paddr[4:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      retry_period_r     <= chfsm_pkg::RST_RETRY_PERIOD;
      link_timeout_r     <= chfsm_pkg::RST_LINK_TIMEOUT;
      keepalive_period_r <= chfsm_pkg::RST_KEEPALIVE_PERIOD;
      max_retries_r      <= chfsm_pkg::RST_MAX_RETRIES;
      local_id_r         <= chfsm_pkg::RST_LOCAL_ID;
    end else if (wr_en) begin
      unique case (idx)
        chfsm_pkg::REG_RETRY_PERIOD:     retry_period_r     <= pwdata[19:0];
        chfsm_pkg::REG_LINK_TIMEOUT:     link_timeout_r     <= pwdata[19:0];
        chfsm_pkg::REG_KEEPALIVE_PERIOD: keepalive_period_r <= pwdata[19:0];
        chfsm_pkg::REG_MAX_RETRIES:      max_retries_r      <= pwdata[7:0];
        chfsm_pkg::REG_LOCAL_ID:         local_id_r         <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      chfsm_pkg::REG_RETRY_PERIOD:     prdata = {12'd0, retry_period_r};
      chfsm_pkg::REG_LINK_TIMEOUT:     prdata = {12'd0, link_timeout_r};
      chfsm_pkg::REG_KEEPALIVE_PERIOD: prdata = {12'd0, keepalive_period_r};
      chfsm_pkg::REG_MAX_RETRIES:      prdata = {24'd0, max_retries_r};
      chfsm_pkg::REG_LOCAL_ID:         prdata = {24'd0, local_id_r};
      default:                         prdata = 32'd0;
    endcase
  end

  assign cfg.retry_period     = retry_period_r;
  assign cfg.link_timeout     = link_timeout_r;
  assign cfg.keepalive_period = keepalive_period_r;
  assign cfg.max_retries      = max_retries_r;

endmodule

// File: hw/rtl/chfsm_engine.sv
// chfsm_engine: link state machine, timers and session registers, plus the combinational
// event decode that forms the result; depends on chfsm_pkg

module chfsm_engine (
  input  logic                clk,
  input  logic                rst_n,
  input  chfsm_pkg::cfg_t     cfg,
  input  logic                fire,
  input  chfsm_pkg::in_item_t item,
  output chfsm_pkg::res_t     res
);

  chfsm_pkg::link_state_t state_r, state_nxt;
  chfsm_pkg::timer_t      rt_r, rt_nxt;
  chfsm_pkg::timer_t      lt_r, lt_nxt;
  chfsm_pkg::timer_t      kt_r, kt_nxt;
  logic [7:0]             rc_r, rc_nxt;
  logic [15:0]            sess_r, sess_nxt;
  logic [2:0]             reason_r, reason_nxt;

  chfsm_pkg::timer_t rt_dec, rt_retry, lt_dec, kt_dec;
  chfsm_pkg::timer_t rt_load, lt_load, kt_load;
  chfsm_pkg::wide_t  el_w;
  logic              handshake;

  assign el_w     = chfsm_pkg::wide_t'({1'b0, item.elapsed});
  assign rt_dec   = chfsm_pkg::sat(chfsm_pkg::wide_t'(rt_r) - el_w);
  // only used once the decremented retry timer has gone negative
  assign rt_retry = chfsm_pkg::sat(chfsm_pkg::wide_t'(rt_dec)
                                   + chfsm_pkg::wide_t'({1'b0, cfg.retry_period}));
  assign lt_dec   = chfsm_pkg::sat(chfsm_pkg::wide_t'(lt_r) - el_w);
  assign kt_dec   = chfsm_pkg::sat(chfsm_pkg::wide_t'(kt_r) - el_w);
  assign rt_load  = chfsm_pkg::load20(cfg.retry_period);
  assign lt_load  = chfsm_pkg::load20(cfg.link_timeout);
  assign kt_load  = chfsm_pkg::load20(cfg.keepalive_period);

  assign handshake = (state_r == chfsm_pkg::LS_CONNECTING)
                  || (state_r == chfsm_pkg::LS_ACCEPTED);

  always_comb begin
    state_nxt  = state_r;
    rt_nxt     = rt_r;
    lt_nxt     = lt_r;
    kt_nxt     = kt_r;
    rc_nxt     = rc_r;
    sess_nxt   = sess_r;
    reason_nxt = reason_r;
    res        = '0;

    unique case (item.func)
      chfsm_pkg::FN_TICK: begin
        if (handshake) begin
          rt_nxt = rt_dec;
          if (rt_dec[chfsm_pkg::TIMER_BITS-1]) begin
            if (rc_r >= cfg.max_retries) begin
              state_nxt        = chfsm_pkg::LS_DISC;
              reason_nxt       = chfsm_pkg::ST_TIMEOUT;
              res.status_valid = 1'b1;
              res.status_code  = chfsm_pkg::ST_TIMEOUT;
            end else begin
              rt_nxt         = rt_retry;
              rc_nxt         = rc_r + 8'd1;
              kt_nxt         = kt_load;
              res.send_valid = 1'b1;
              // resend whichever handshake message this side owns
              if (state_r == chfsm_pkg::LS_ACCEPTED) begin
                res.send_kind    = chfsm_pkg::K_ACCEPTED;
                res.send_session = sess_r;
              end else begin
                res.send_kind    = chfsm_pkg::K_CONNECT;
              end
            end
          end
        end else if (state_r == chfsm_pkg::LS_CONNECTED) begin
          lt_nxt = lt_dec;
          kt_nxt = kt_dec;
          if (lt_dec[chfsm_pkg::TIMER_BITS-1]) begin
            state_nxt        = chfsm_pkg::LS_DISC;
            reason_nxt       = chfsm_pkg::ST_TIMEOUT;
            res.status_valid = 1'b1;
            res.status_code  = chfsm_pkg::ST_TIMEOUT;
          end else if (kt_dec[chfsm_pkg::TIMER_BITS-1]) begin
            kt_nxt          = kt_load;
            res.send_valid  = 1'b1;
            res.send_kind   = chfsm_pkg::K_PING;
            res.send_time_a = item.local_now;
          end
        end
      end
      chfsm_pkg::FN_START: begin
        state_nxt        = chfsm_pkg::LS_CONNECTING;
        rt_nxt           = rt_load;
        lt_nxt           = lt_load;
        rc_nxt           = 8'd0;
        kt_nxt           = kt_load;
        res.send_valid   = 1'b1;
        res.send_kind    = chfsm_pkg::K_CONNECT;
        res.status_valid = 1'b1;
        res.status_code  = chfsm_pkg::ST_CONNECTING;
      end
      chfsm_pkg::FN_DISCONNECT: begin
        if (state_r != chfsm_pkg::LS_DISC) begin
          kt_nxt           = kt_load;
          res.send_valid   = 1'b1;
          res.send_kind    = chfsm_pkg::K_PING;
          res.send_time_a  = item.local_now;
          reason_nxt       = chfsm_pkg::ST_DISCONNECTED;
          state_nxt        = chfsm_pkg::LS_DISC;
          res.status_valid = 1'b1;
          res.status_code  = chfsm_pkg::ST_DISCONNECTED;
        end
      end
      chfsm_pkg::FN_RX_CONNECT: begin
        lt_nxt           = lt_load;
        kt_nxt           = kt_load;
        res.send_valid   = 1'b1;
        res.send_kind    = chfsm_pkg::K_ACCEPTED;
        res.send_session = sess_r;
        if (state_r == chfsm_pkg::LS_DISC) begin
          state_nxt        = chfsm_pkg::LS_ACCEPTED;
          rt_nxt           = rt_load;
          rc_nxt           = 8'd0;
          sess_nxt         = item.peer_session;
          res.send_session = item.peer_session;
          res.status_valid = 1'b1;
          res.status_code  = chfsm_pkg::ST_CONNECTING;
        end
      end
      chfsm_pkg::FN_RX_ACCEPTED: begin
        lt_nxt = lt_load;
        if (state_r == chfsm_pkg::LS_CONNECTING) begin
          rt_nxt           = '0;
          rc_nxt           = 8'd0;
          sess_nxt         = item.peer_session;
          kt_nxt           = kt_load;
          res.send_valid   = 1'b1;
          res.send_kind    = chfsm_pkg::K_CONN_ACK;
          state_nxt        = chfsm_pkg::LS_CONNECTED;
          res.status_valid = 1'b1;
          res.status_code  = chfsm_pkg::ST_CONNECTED;
        end
      end
      chfsm_pkg::FN_RX_DENIED: begin
        if (state_r == chfsm_pkg::LS_CONNECTING) begin
          state_nxt        = chfsm_pkg::LS_DISC;
          res.status_valid = 1'b1;
          if (item.deny_reason == chfsm_pkg::DR_USER_LIMIT) begin
            reason_nxt      = chfsm_pkg::ST_USER_LIMIT;
            res.status_code = chfsm_pkg::ST_USER_LIMIT;
          end else begin
            reason_nxt      = chfsm_pkg::ST_BY_SERVER;
            // the unused deny codes are reported as other denial
            res.status_code = (item.deny_reason == chfsm_pkg::DR_BY_SERVER)
                            ? chfsm_pkg::ST_BY_SERVER : chfsm_pkg::ST_OTHER_DENIAL;
          end
        end
      end
      chfsm_pkg::FN_RX_CONN_ACK: begin
        lt_nxt = lt_load;
        if (state_r == chfsm_pkg::LS_ACCEPTED) begin
          rt_nxt           = '0;
          rc_nxt           = 8'd0;
          state_nxt        = chfsm_pkg::LS_CONNECTED;
          res.status_valid = 1'b1;
          res.status_code  = chfsm_pkg::ST_CONNECTED;
        end
      end
      chfsm_pkg::FN_RX_PING, chfsm_pkg::FN_RX_PONG, chfsm_pkg::FN_RX_ACK: begin
        lt_nxt = lt_load;
        if (handshake) begin
          state_nxt        = chfsm_pkg::LS_CONNECTED;
          res.status_valid = 1'b1;
          res.status_code  = chfsm_pkg::ST_CONNECTED;
        end
        if (item.func == chfsm_pkg::FN_RX_PING) begin
          kt_nxt          = kt_load;
          res.send_valid  = 1'b1;
          res.send_kind   = chfsm_pkg::K_PONG;
          res.send_time_a = item.time_stamp;
          res.send_time_b = item.local_now;
        end
        if (item.func == chfsm_pkg::FN_RX_PONG) begin
          res.rtt_valid = 1'b1;
          res.rtt_value = item.local_now - item.time_stamp;
        end
      end
      chfsm_pkg::FN_RX_DATA: begin
        lt_nxt = lt_load;
      end
      default: ;
    endcase

    res.link_state        = chfsm_pkg::ls_encode(state_nxt);
    res.disconnect_reason = reason_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= chfsm_pkg::LS_DISC;
      rt_r     <= chfsm_pkg::load20(chfsm_pkg::RST_RETRY_PERIOD);
      lt_r     <= '0;
      kt_r     <= chfsm_pkg::load20(chfsm_pkg::RST_KEEPALIVE_PERIOD);
      rc_r     <= 8'd0;
      sess_r   <= 16'd0;
      reason_r <= chfsm_pkg::ST_NONE;
    end else if (fire) begin
      state_r  <= state_nxt;
      rt_r     <= rt_nxt;
      lt_r     <= lt_nxt;
      kt_r     <= kt_nxt;
      rc_r     <= rc_nxt;
      sess_r   <= sess_nxt;
      reason_r <= reason_nxt;
    end
  end

endmodule
